@@ sv/rmv_pkg.sv @@
// Shared constants and the control state type of the running statistics block.
package rmv_pkg;

	localparam int WEIGHT_FRAC = 16;
	localparam int WEIGHT_WIDTH = WEIGHT_FRAC + 1;
	localparam int MUL_DIGIT = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_MEAN_GO,
		ST_MEAN_RUN,
		ST_MEAN_FIN,
		ST_SQR_GO,
		ST_SQR_RUN,
		ST_SQR_FIN,
		ST_VAR_GO,
		ST_VAR_RUN,
		ST_VAR_FIN,
		ST_OUT
	} rmv_state_t;

endpackage

@@ sv/rmv_mul.sv @@
// Digit-serial signed by unsigned multiplier, multiplier digits taken MSB first.
module rmv_mul #(
	parameter int A_W = 47,
	parameter int B_W = 17,
	parameter int DIGIT = 2,
	localparam int P_W = A_W + B_W,
	localparam int STEPS = (B_W + DIGIT - 1) / DIGIT,
	localparam int BP_W = STEPS * DIGIT,
	localparam int CNT_W = $clog2(STEPS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [A_W-1:0] a,
	input  logic        [B_W-1:0] b,
	output logic                  busy,
	output logic signed [P_W-1:0] p
);

	logic signed [P_W-1:0] a_q;
	logic        [BP_W-1:0] b_q;
	logic signed [P_W-1:0] acc_q;
	logic        [CNT_W-1:0] cnt_q;
	logic                   busy_q;
	logic        [DIGIT-1:0] digit;
	logic signed [P_W-1:0] pp;
	logic signed [P_W-1:0] acc_next;

	always_comb begin
		digit = b_q[BP_W-1 -: DIGIT];
		pp = '0;
		for (int j = 0; j < DIGIT; j++) begin
			if (digit[j]) begin
				pp = pp + (a_q <<< j);
			end
		end
		acc_next = (acc_q <<< DIGIT) + pp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= P_W'(a);
			b_q <= BP_W'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q <= b_q << DIGIT;
		end
	end

	assign busy = busy_q;
	assign p = acc_q;

endmodule

@@ sv/rmv_div.sv @@
// Restoring divider for the count-mode new-sample weight, one quotient bit per cycle.
module rmv_div #(
	parameter int COUNT_WIDTH = 32,
	localparam int D_W = COUNT_WIDTH + 1,
	localparam int R_W = COUNT_WIDTH + rmv_pkg::WEIGHT_WIDTH,
	localparam int CNT_W = $clog2(rmv_pkg::WEIGHT_WIDTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [COUNT_WIDTH-1:0]            count,
	output logic                              busy,
	output logic [rmv_pkg::WEIGHT_WIDTH-1:0]  quot
);

	import rmv_pkg::*;

	logic [D_W-1:0]          d;
	logic [R_W-1:0]          num;
	logic [R_W-1:0]          rem_q;
	logic [R_W-1:0]          ds_q;
	logic [WEIGHT_WIDTH-1:0] q_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    take;

	always_comb begin
		d = D_W'(count) + D_W'(1);
		num = (R_W'(1) << WEIGHT_FRAC) + R_W'(d >> 1);
		take = (rem_q >= ds_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(WEIGHT_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			ds_q <= R_W'(d) << (WEIGHT_WIDTH - 1);
			q_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - ds_q;
			end
			q_q <= {q_q[WEIGHT_WIDTH-2:0], take};
			ds_q <= ds_q >> 1;
		end
	end

	assign busy = busy_q;
	assign quot = q_q;

endmodule

@@ sv/running_mean_variance_minmax_top.sv @@
// Top level of the running mean, variance, count, minimum and maximum block.
//
//   Channel   Dir  Signals                     Payload
//   s_axis    in   tvalid tready tdata tuser   sample, old_weight, new_weight; opcode
//   m_axis    out  tvalid tready tdata         mean, variance, count, minimum, maximum
//
// In count mode an item first goes through the weight divider; with supplied weights
// it starts at the mean step. Radix-4 serial multipliers (9 steps for weights, 16 steps
// for the squares) form the products; one item is in work at a time.
// Reset clears the statistics at once, with no clearing pass.
// A result waits in the output register while the next item is taken and worked on;
// that item stalls only at its own output step if the result is still not taken.
module running_mean_variance_minmax_top #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS = 16,
	parameter int COUNT_WIDTH = 32,
	localparam int IN_BITS = SAMPLE_WIDTH + 2 * rmv_pkg::WEIGHT_WIDTH,
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = (SAMPLE_WIDTH + FRAC_BITS) + (2 * SAMPLE_WIDTH - 2 + FRAC_BITS)
		+ COUNT_WIDTH + 2 * SAMPLE_WIDTH,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// sample, old_weight, new_weight, zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	// opcode
	input  logic             s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// mean, variance, count, minimum, maximum, zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	import rmv_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int MW = SAMPLE_WIDTH + FRAC_BITS;
	localparam int VW = 2 * SAMPLE_WIDTH - 2 + FRAC_BITS;
	localparam int WW = WEIGHT_WIDTH;
	localparam int AW = VW + 1;
	localparam int PW = AW + WW;
	localparam int SQP = 2 * MW + 1;
	localparam int SQR_W = 2 * MW - FRAC_BITS + 1;
	localparam int VS_W = PW - WEIGHT_FRAC + 2;
	localparam logic signed [PW:0] MEAN_HALF =
		{{(PW + 1 - WEIGHT_FRAC){1'b0}}, 1'b1, {(WEIGHT_FRAC - 1){1'b0}}};

	rmv_state_t state_q, state_d;

	logic signed [SW-1:0]  x_q;
	logic        [WW-1:0]  pw_q;
	logic        [WW-1:0]  nw_q;
	logic signed [MW-1:0]  mean_q;
	logic        [VW-1:0]  var_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic signed [SW-1:0]  min_q;
	logic signed [SW-1:0]  max_q;
	logic signed [MW-1:0]  mnew_q;
	logic                  sat0_q;
	logic                  sat1_q;
	logic        [VW-1:0]  sq0_q;
	logic        [VW-1:0]  sq1_q;
	logic [OUT_W-1:0]      out_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  div_start;
	logic                  mul_start;
	logic                  sq_start;
	logic                  out_load;
	logic                  div_busy;
	logic [WW-1:0]         div_quot;
	logic                  mul0_busy;
	logic                  mul1_busy;
	logic                  mul_busy;
	logic                  sq0_busy;
	logic                  sq1_busy;
	logic                  sq_busy;
	logic signed [AW-1:0]  a0;
	logic signed [AW-1:0]  a1;
	logic signed [PW-1:0]  p0;
	logic signed [PW-1:0]  p1;
	logic signed [MW:0]    sqa0;
	logic signed [MW:0]    sqa1;
	logic signed [SQP-1:0] sqp0;
	logic signed [SQP-1:0] sqp1;

	logic signed [MW-1:0]  xq;
	logic signed [PW:0]    macc;
	logic signed [PW:0]    mshift;
	logic        [MW-1:0]  mclip;
	logic signed [MW:0]    d0;
	logic signed [MW:0]    d1;
	logic        [MW:0]    u0;
	logic        [MW:0]    u1;
	logic        [VW:0]    inner_sum;
	logic        [VW-1:0]  inner;
	logic        [PW:0]    vsum;
	logic        [VS_W-1:0] vround;
	logic        [VW-1:0]  vclip;

	function automatic logic [VW-1:0] round_sq(input logic [2*MW-1:0] pr, input logic ovf);
		logic [SQR_W-1:0] q;
		q = SQR_W'(pr[2*MW-1:FRAC_BITS]) + SQR_W'(pr[FRAC_BITS-1]);
		if (ovf || (|q[SQR_W-1:VW])) begin
			round_sq = '1;
		end else begin
			round_sq = q[VW-1:0];
		end
	endfunction

	rmv_div #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.count(count_q),
		.busy(div_busy),
		.quot(div_quot)
	);

	rmv_mul #(.A_W(AW), .B_W(WW), .DIGIT(MUL_DIGIT)) u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(a0), .b(pw_q), .busy(mul0_busy), .p(p0)
	);

	rmv_mul #(.A_W(AW), .B_W(WW), .DIGIT(MUL_DIGIT)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(a1), .b(nw_q), .busy(mul1_busy), .p(p1)
	);

	rmv_mul #(.A_W(MW + 1), .B_W(MW), .DIGIT(MUL_DIGIT)) u_sq0 (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.a(sqa0), .b(u0[MW-1:0]), .busy(sq0_busy), .p(sqp0)
	);

	rmv_mul #(.A_W(MW + 1), .B_W(MW), .DIGIT(MUL_DIGIT)) u_sq1 (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.a(sqa1), .b(u1[MW-1:0]), .busy(sq1_busy), .p(sqp1)
	);

	assign mul_busy = mul0_busy | mul1_busy;
	assign sq_busy = sq0_busy | sq1_busy;

	always_comb begin
		xq = $signed({x_q, {FRAC_BITS{1'b0}}});

		macc = (PW + 1)'(p0) + (PW + 1)'(p1) + MEAN_HALF;
		mshift = macc >>> WEIGHT_FRAC;
		if ((&mshift[PW:MW-1]) || !(|mshift[PW:MW-1])) begin
			mclip = mshift[MW-1:0];
		end else if (mshift[PW]) begin
			mclip = {1'b1, {(MW - 1){1'b0}}};
		end else begin
			mclip = {1'b0, {(MW - 1){1'b1}}};
		end

		d0 = (MW + 1)'(mnew_q) - (MW + 1)'(mean_q);
		d1 = (MW + 1)'(mnew_q) - (MW + 1)'(xq);
		u0 = d0[MW] ? $unsigned(-d0) : $unsigned(d0);
		u1 = d1[MW] ? $unsigned(-d1) : $unsigned(d1);
		sqa0 = $signed({1'b0, u0[MW-1:0]});
		sqa1 = $signed({1'b0, u1[MW-1:0]});

		inner_sum = (VW + 1)'(var_q) + (VW + 1)'(sq0_q);
		inner = inner_sum[VW] ? '1 : inner_sum[VW-1:0];

		if (state_q == ST_VAR_GO) begin
			a0 = $signed({1'b0, inner});
			a1 = $signed({1'b0, sq1_q});
		end else begin
			a0 = AW'(mean_q);
			a1 = AW'(xq);
		end

		vsum = (PW + 1)'($unsigned(p0)) + (PW + 1)'($unsigned(p1));
		vround = VS_W'(vsum[PW:WEIGHT_FRAC]) + VS_W'(vsum[WEIGHT_FRAC-1]);
		vclip = (|vround[VS_W-1:VW]) ? '1 : vround[VW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = s_axis_tuser ? ST_MEAN_GO : ST_DIV_GO;
				end
			end
			ST_DIV_GO: state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (!div_busy) begin
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: state_d = ST_MEAN_RUN;
			ST_MEAN_RUN: begin
				if (!mul_busy) begin
					state_d = ST_MEAN_FIN;
				end
			end
			ST_MEAN_FIN: state_d = ST_SQR_GO;
			ST_SQR_GO: state_d = ST_SQR_RUN;
			ST_SQR_RUN: begin
				if (!sq_busy) begin
					state_d = ST_SQR_FIN;
				end
			end
			ST_SQR_FIN: state_d = ST_VAR_GO;
			ST_VAR_GO: state_d = ST_VAR_RUN;
			ST_VAR_RUN: begin
				if (!mul_busy) begin
					state_d = ST_VAR_FIN;
				end
			end
			ST_VAR_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		div_start = (state_q == ST_DIV_GO);
		mul_start = (state_q == ST_MEAN_GO) || (state_q == ST_VAR_GO);
		sq_start = (state_q == ST_SQR_GO);
		out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mean_q <= '0;
			var_q <= '0;
			count_q <= '0;
			min_q <= {1'b0, {(SW - 1){1'b1}}};
			max_q <= {1'b1, {(SW - 1){1'b0}}};
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_VAR_FIN) begin
				mean_q <= mnew_q;
				var_q <= vclip;
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				if (x_q < min_q) begin
					min_q <= x_q;
				end
				if (x_q > max_q) begin
					max_q <= x_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= $signed(s_axis_tdata[SW-1:0]);
			pw_q <= s_axis_tdata[SW +: WW];
			nw_q <= s_axis_tdata[SW + WW +: WW];
		end
		if ((state_q == ST_DIV_RUN) && !div_busy) begin
			nw_q <= div_quot;
			pw_q <= (WW'(1) << WEIGHT_FRAC) - div_quot;
		end
		if (state_q == ST_MEAN_FIN) begin
			mnew_q <= $signed(mclip);
		end
		if (state_q == ST_SQR_GO) begin
			sat0_q <= u0[MW];
			sat1_q <= u1[MW];
		end
		if (state_q == ST_SQR_FIN) begin
			sq0_q <= round_sq(sqp0[2*MW-1:0], sat0_q);
			sq1_q <= round_sq(sqp1[2*MW-1:0], sat1_q);
		end
		if (out_load) begin
			out_q <= OUT_W'({max_q, min_q, count_q, var_q, mean_q});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");

	a_result_from_out_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("sample count went down");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> min_q <= max_q)
		else $error("minimum above maximum after samples");

	a_mul_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy |-> (state_q == ST_MEAN_RUN) || (state_q == ST_VAR_RUN))
		else $error("weight multipliers running outside their steps");

endmodule

@@ tb/running_mean_variance_minmax_top_tb.sv @@
// Testbench for the running mean, variance, count, minimum and maximum block.
`timescale 1ns / 100ps

module running_mean_variance_minmax_top_tb;

	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = rmv_pkg::WEIGHT_WIDTH;
	localparam int IN_W = 56;
	localparam int OUT_W = 144;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_WEIGHTS = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 16'sh8000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 17'h1FFFF;
	localparam longint MEAN_TOP = 64'sh7FFF_FFFF;
	localparam longint MEAN_BOTTOM = -64'sh8000_0000;
	localparam longint unsigned VAR_TOP = 64'h0000_3FFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

	typedef struct {
		logic signed [31:0] mean;
		logic [45:0] variance;
		logic [31:0] count;
		logic signed [15:0] minimum;
		logic signed [15:0] maximum;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// sample, old_weight, new_weight, zero fill
	logic [IN_W-1:0] s_axis_tdata = '0;
	// opcode
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// mean, variance, count, minimum, maximum, zero fill
	logic [OUT_W-1:0] m_axis_tdata;

	logic signed [31:0] mean_st;
	logic [45:0] var_st;
	logic [31:0] count_st;
	logic signed [15:0] min_st;
	logic signed [15:0] max_st;

	stats_t expected_stats[$];
	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	running_mean_variance_minmax_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint unsigned square_round(input longint d);
		longint unsigned u;
		longint unsigned p;
		longint unsigned q;
		u = (d < 0) ? -d : d;
		if (u >= 64'h1_0000_0000)
			return VAR_TOP;
		p = u * u;
		q = (p >> 16) + ((p >> 15) & 64'd1);
		return (q > VAR_TOP) ? VAR_TOP : q;
	endfunction

	function automatic stats_t next_stats(input logic signed [15:0] smp, input logic op,
			input logic [WEIGHT_W-1:0] ow, input logic [WEIGHT_W-1:0] nw_in);
		longint x;
		longint xq;
		longint old_mean;
		longint acc;
		longint m;
		longint unsigned pw;
		longint unsigned nw;
		longint unsigned div;
		longint unsigned inner;
		longint unsigned dev;
		longint unsigned vsum;
		longint unsigned v;
		stats_t r;
		x = smp;
		if (op == OP_COUNT) begin
			div = {32'd0, count_st} + 64'd1;
			nw = (64'd65536 + div / 64'd2) / div;
			pw = 64'd65536 - nw;
		end else begin
			pw = {47'd0, ow};
			nw = {47'd0, nw_in};
		end
		xq = x * 64'sd65536;
		old_mean = mean_st;
		acc = longint'(pw) * old_mean + longint'(nw) * xq + 64'sd32768;
		m = acc >>> 16;
		if (m > MEAN_TOP)
			m = MEAN_TOP;
		if (m < MEAN_BOTTOM)
			m = MEAN_BOTTOM;
		inner = {18'd0, var_st} + square_round(m - old_mean);
		if (inner > VAR_TOP)
			inner = VAR_TOP;
		dev = square_round(m - xq);
		vsum = pw * inner + nw * dev;
		v = (vsum >> 16) + ((vsum >> 15) & 64'd1);
		if (v > VAR_TOP)
			v = VAR_TOP;
		mean_st = m[31:0];
		var_st = v[45:0];
		if (smp < min_st)
			min_st = smp;
		if (smp > max_st)
			max_st = smp;
		if (count_st != COUNT_TOP)
			count_st = count_st + 32'd1;
		r.mean = mean_st;
		r.variance = var_st;
		r.count = count_st;
		r.minimum = min_st;
		r.maximum = max_st;
		return r;
	endfunction

	always @(posedge clk) begin
		stats_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_stats.size() == 0) begin
					$error("result with no item waiting: %h", m_axis_tdata);
					error_count++;
				end else begin
					want = expected_stats.pop_front();
					if (m_axis_tdata[31:0] !== want.mean) begin
						$error("mean: expected %0d, got %0d", want.mean,
							$signed(m_axis_tdata[31:0]));
						error_count++;
					end
					if (m_axis_tdata[77:32] !== want.variance) begin
						$error("variance: expected %0d, got %0d", want.variance,
							m_axis_tdata[77:32]);
						error_count++;
					end
					if (m_axis_tdata[109:78] !== want.count) begin
						$error("count: expected %0d, got %0d", want.count,
							m_axis_tdata[109:78]);
						error_count++;
					end
					if (m_axis_tdata[125:110] !== want.minimum) begin
						$error("minimum: expected %0d, got %0d", want.minimum,
							$signed(m_axis_tdata[125:110]));
						error_count++;
					end
					if (m_axis_tdata[141:126] !== want.maximum) begin
						$error("maximum: expected %0d, got %0d", want.maximum,
							$signed(m_axis_tdata[141:126]));
						error_count++;
					end
				end
			end
		end
	end

	task automatic send_item(input logic signed [15:0] smp, input logic op,
			input logic [WEIGHT_W-1:0] ow, input logic [WEIGHT_W-1:0] nw);
		int gap;
		gap = 0;
		if (send_idle_pct > 0 && $urandom_range(99) < 5)
			gap = $urandom_range(80, 1);
		while (1) begin
			if (gap > 0)
				gap--;
			else if ($urandom_range(99) >= send_idle_pct)
				break;
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - SAMPLE_W - 2 * WEIGHT_W){1'b0}}, nw, ow, smp};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_stats.push_back(next_stats(smp, op, ow, nw));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extreme_samples();
		send_item(16'sd0, OP_COUNT, WEIGHT_FULL, WEIGHT_FULL);
		send_item(SAMPLE_TOP, OP_COUNT, '0, '0);
		send_item(SAMPLE_BOTTOM, OP_COUNT, WEIGHT_ONE, '0);
		send_item(-16'sd1, OP_COUNT, '0, WEIGHT_FULL);
		send_item(16'sd1, OP_COUNT, 17'h0AAAA, 17'h15555);
	endtask

	task automatic test_supplied_weights();
		send_item(SAMPLE_TOP, OP_WEIGHTS, WEIGHT_ONE, '0);
		send_item(SAMPLE_BOTTOM, OP_WEIGHTS, '0, WEIGHT_ONE);
		send_item(16'sd100, OP_WEIGHTS, '0, '0);
		send_item(-16'sd5, OP_WEIGHTS, 17'h08000, 17'h08000);
		send_item(16'sd1234, OP_WEIGHTS, WEIGHT_FULL, WEIGHT_FULL);
		send_item(16'sd0, OP_WEIGHTS, WEIGHT_ONE, WEIGHT_ONE);
	endtask

	task automatic test_saturation();
		send_item(SAMPLE_TOP, OP_WEIGHTS, '0, WEIGHT_FULL);
		send_item(SAMPLE_BOTTOM, OP_WEIGHTS, '0, WEIGHT_FULL);
		repeat (3)
			send_item(SAMPLE_TOP, OP_WEIGHTS, WEIGHT_FULL, WEIGHT_FULL);
		repeat (2)
			send_item(SAMPLE_BOTTOM, OP_WEIGHTS, WEIGHT_FULL, WEIGHT_FULL);
		send_item(16'sd7, OP_WEIGHTS, '0, WEIGHT_ONE);
		send_item(-16'sd7, OP_COUNT, '0, '0);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic signed [15:0] smp;
		logic op;
		logic [WEIGHT_W-1:0] ow;
		logic [WEIGHT_W-1:0] nw;
		int pick;
		repeat (n_items) begin
			pick = $urandom_range(99);
			smp = SAMPLE_W'($urandom);
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(3))
					0: smp = SAMPLE_TOP;
					1: smp = SAMPLE_BOTTOM;
					2: smp = 16'sd0;
					default: smp = -16'sd1;
				endcase
			end
			ow = WEIGHT_W'($urandom);
			nw = WEIGHT_W'($urandom);
			op = (pick < 60) ? OP_COUNT : OP_WEIGHTS;
			if (pick >= 60 && pick < 80) begin
				nw = WEIGHT_W'($urandom_range(65536));
				ow = WEIGHT_ONE - nw;
			end else if (pick >= 80 && pick < 90) begin
				ow = WEIGHT_W'($urandom_range(65536));
				nw = WEIGHT_W'($urandom_range(65536));
			end else if (pick >= 95) begin
				ow = '0;
				nw = WEIGHT_ONE;
			end
			send_item(smp, op, ow, nw);
		end
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			wait_drained();
			test_random_traffic(1);
		end
	endtask

	initial begin
		mean_st = '0;
		var_st = '0;
		count_st = '0;
		min_st = SAMPLE_TOP;
		max_st = SAMPLE_BOTTOM;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 28;
		recv_idle_pct = 60;
		test_extreme_samples();
		test_supplied_weights();
		test_saturation();
		test_drain_pause();
		test_random_traffic(560);

		send_idle_pct = 60;
		recv_idle_pct = 28;
		test_random_traffic(560);
		test_drain_pause();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(580);

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
sv/rmv_pkg.sv
sv/rmv_mul.sv
sv/rmv_div.sv
sv/running_mean_variance_minmax_top.sv
tb/running_mean_variance_minmax_top_tb.sv
